[hw/rtl/mph_pkg.sv]
// Shared types, codes and the ranking rule of the max priority heap.
// Depends on nothing; used by max_priority_heap_unit.
package mph_pkg;

  // Operation codes of an input beat.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored entry: quality key and identifier.
  typedef struct packed {
    logic [15:0] quality;
    logic [15:0] id;
  } entry_t;

  // True when entry a ranks below entry b: lower quality, or equal quality
  // and a higher id. Equal entries never rank below each other.
  function automatic logic ranks_below(entry_t a, entry_t b);
    logic res;
    if (a.quality != b.quality) begin
      res = (b.quality > a.quality);
    end else begin
      res = (b.id < a.id);
    end
    return res;
  endfunction

endpackage

[hw/rtl/max_priority_heap_unit.sv]
// Max priority heap: top level with the entry memory and the sift sequencer.
// Depends on mph_pkg.
//
// A binary max-heap of up to CAPACITY entries, each a 16-bit quality and a
// 16-bit id; higher quality ranks first and a lower id wins ties. One input
// beat inserts an entry or removes the top entry, and each yields one result
// beat with the new top entry, its validity, the entry count and a status
// (insert into a full heap or remove from an empty one is rejected and leaves
// the heap as it was). Entries live in a synchronous memory with one write
// port and one registered read port; the sequencer moves a hole through the
// tree. Each level an insert climbs costs a parent read and a compare, and
// each level a remove descends costs a left-child read, a right-child read
// and a compare; a remove first fetches the last entry. One item is worked
// on at a time, and the next is accepted while the previous result still
// waits.
module max_priority_heap_unit
  import mph_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [15:0] entry_quality_i,
  input  logic [15:0] entry_id_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] top_quality_o,
  output logic [15:0] top_id_o,
  output logic        top_valid_o,
  output logic [8:0]  entry_count_o,
  output logic [1:0]  status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_RD   = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_DN_LAST = 9'b000001000,
    S_DN_LOAD = 9'b000010000,
    S_DN_RDL  = 9'b000100000,
    S_DN_RDR  = 9'b001000000,
    S_DN_CMP  = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  pos_q, pos_d;
  entry_t         mov_q, mov_d;
  entry_t         left_q, left_d;
  logic           has_right_q, has_right_d;
  entry_t         top_q, top_d;
  status_e        status_q, status_d;
  logic           out_valid_q;

  // Memory port signals.
  entry_t         mem [CAPACITY];
  logic           we;
  logic [AW-1:0]  waddr;
  entry_t         wdata;
  logic [AW-1:0]  raddr;
  entry_t         rdata_q;

  // Tree index arithmetic in a width that holds both children.
  logic [WW-1:0]  cnt_w;
  logic [WW-1:0]  left_w;
  logic [WW-1:0]  right_w;
  logic [AW-1:0]  parent;
  entry_t         best;
  logic [AW-1:0]  best_idx;
  logic           right_wins;
  logic           in_fire;
  logic           out_free;
  logic [CW+8:0]  cnt_ext;

  assign cnt_w    = WW'(cnt_q);
  assign left_w   = (WW'(pos_q) << 1) + WW'(1);
  assign right_w  = (WW'(pos_q) << 1) + WW'(2);
  assign parent   = (pos_q - AW'(1)) >> 1;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Child selection for a sift-down step: the right child wins only when
  // it exists and the left one ranks below it.
  assign right_wins = has_right_q && ranks_below(left_q, rdata_q);
  assign best       = right_wins ? rdata_q : left_q;
  assign best_idx   = right_wins ? right_w[AW-1:0] : left_w[AW-1:0];

  assign in_ready_o = (state_q == S_IDLE);

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Sequencer: next state and memory control.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    mov_d       = mov_q;
    left_d      = left_q;
    has_right_d = has_right_q;
    status_d    = status_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = mov_q;
    raddr       = pos_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          status_d = ST_DONE;
          if (operation_i == OP_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              mov_d.quality = entry_quality_i;
              mov_d.id      = entry_id_i;
              pos_d         = cnt_q[AW-1:0];
              cnt_d         = cnt_q + CW'(1);
              state_d       = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              cnt_d   = cnt_q - CW'(1);
              state_d = S_DN_LAST;
            end
          end
        end
      end

      // Sift up: read the parent of the hole, or settle at the root.
      S_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_FIN;
        end else begin
          raddr   = parent;
          state_d = S_UP_CMP;
        end
      end

      // Move the parent down into the hole when it ranks below the new entry, else settle there.
      S_UP_CMP: begin
        we = 1'b1;
        if (ranks_below(rdata_q, mov_q)) begin
          wdata   = rdata_q;
          pos_d   = parent;
          state_d = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end

      // Remove: fetch the last entry, which becomes the moving entry.
      S_DN_LAST: begin
        raddr   = cnt_q[AW-1:0];
        pos_d   = '0;
        state_d = S_DN_LOAD;
      end

      S_DN_LOAD: begin
        mov_d   = rdata_q;
        state_d = (cnt_q == '0) ? S_FIN : S_DN_RDL;
      end

      // Sift down: read the left child, or settle at a leaf.
      S_DN_RDL: begin
        if (left_w >= cnt_w) begin
          we      = 1'b1;
          state_d = S_FIN;
        end else begin
          raddr   = left_w[AW-1:0];
          state_d = S_DN_RDR;
        end
      end

      // Keep the left child and read the right one.
      S_DN_RDR: begin
        left_d      = rdata_q;
        has_right_d = (right_w < cnt_w);
        raddr       = right_w[AW-1:0];
        state_d     = S_DN_CMP;
      end

      // Move the better child up into the hole when the moving entry ranks
      // below it, else settle the moving entry there.
      S_DN_CMP: begin
        we = 1'b1;
        if (ranks_below(mov_q, best)) begin
          wdata   = best;
          pos_d   = best_idx;
          state_d = S_DN_RDL;
        end else begin
          state_d = S_FIN;
        end
      end

      // Wait for the result register to be free.
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Shadow copy of the root entry, updated by every write to the root.
  always_comb begin
    top_d = top_q;
    if (we && (waddr == '0)) begin
      top_d = wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    mov_q       <= mov_d;
    left_q      <= left_d;
    has_right_q <= has_right_d;
    top_q       <= top_d;
    status_q    <= status_d;
  end

  // Result register, loaded when an item finishes.
  assign cnt_ext = {9'd0, cnt_q};

  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && out_free) begin
      top_valid_o   <= (cnt_q != '0);
      top_quality_o <= (cnt_q != '0) ? top_q.quality : 16'd0;
      top_id_o      <= (cnt_q != '0) ? top_q.id : 16'd0;
      entry_count_o <= cnt_ext[8:0];
      status_o      <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[tb/sv/max_priority_heap_unit_tb.sv]
// Self-checking testbench for max_priority_heap_unit: drives insert and remove beats
// and checks every result beat against a heap predictor kept in the testbench.
// Depends on mph_pkg and max_priority_heap_unit.
module max_priority_heap_unit_tb;
  import mph_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_DEPTH = 256;

  // Expected contents of one result beat.
  typedef struct {
    logic [15:0] quality;
    logic [15:0] id;
    logic        valid;
    logic [8:0]  count;
    status_e     status;
  } heap_top_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = OP_INSERT;
  logic [15:0] entry_quality_i = '0;
  logic [15:0] entry_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] top_quality_o;
  logic [15:0] top_id_o;
  logic        top_valid_o;
  logic [8:0]  entry_count_o;
  logic [1:0]  status_o;

  // Predictor state: the heap array and its fill level.
  entry_t      heap_model [HEAP_DEPTH];
  int unsigned heap_fill = 0;
  heap_top_t   pending_tops [$];

  // Run bookkeeping.
  bit          gaps_on = 1'b1;
  int unsigned err_count = 0;
  int unsigned n_insert = 0;
  int unsigned n_remove = 0;
  int unsigned n_full = 0;
  int unsigned n_empty = 0;
  int unsigned n_checked = 0;
  int unsigned peak_fill = 0;

  max_priority_heap_unit #(
    .CAPACITY(HEAP_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .entry_quality_i(entry_quality_i),
    .entry_id_i     (entry_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_quality_o  (top_quality_o),
    .top_id_o       (top_id_o),
    .top_valid_o    (top_valid_o),
    .entry_count_o  (entry_count_o),
    .status_o       (status_o)
  );

  // Free-running clock, 20 ns period.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Entry a goes above entry b: higher quality, or the same quality and a lower id.
  function automatic bit outranks(entry_t a, entry_t b);
    if (a.quality != b.quality) begin
      return a.quality > b.quality;
    end
    return a.id < b.id;
  endfunction

  // Apply one operation to the predictor heap and return the result it must report.
  function automatic heap_top_t predict_heap_step(logic op, logic [15:0] key_q,
                                                  logic [15:0] key_id);
    heap_top_t   res;
    int unsigned pos;
    int unsigned up;
    int unsigned child;
    entry_t      tmp;
    res.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = heap_fill;
        heap_model[pos] = {key_q, key_id};
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!outranks(heap_model[pos], heap_model[up])) break;
          tmp = heap_model[up];
          heap_model[up] = heap_model[pos];
          heap_model[pos] = tmp;
          pos = up;
        end
        heap_fill++;
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = ST_EMPTY;
      end else begin
        heap_fill--;
        heap_model[0] = heap_model[heap_fill];
        pos = 0;
        forever begin
          child = 2 * pos + 1;
          if (child >= heap_fill) break;
          // Ties between siblings keep the left child.
          if (child + 1 < heap_fill && outranks(heap_model[child + 1], heap_model[child])) begin
            child = child + 1;
          end
          if (!outranks(heap_model[child], heap_model[pos])) break;
          tmp = heap_model[child];
          heap_model[child] = heap_model[pos];
          heap_model[pos] = tmp;
          pos = child;
        end
      end
    end
    res.valid = (heap_fill > 0);
    res.quality = res.valid ? heap_model[0].quality : 16'd0;
    res.id = res.valid ? heap_model[0].id : 16'd0;
    res.count = heap_fill[8:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Send one beat; valid stays high afterwards unless the next call idles first.
  task automatic send_beat(logic op, logic [15:0] key_q, logic [15:0] key_id);
    heap_top_t want;
    if (gaps_on) begin
      while ($urandom_range(99) < 12) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    entry_quality_i <= key_q;
    entry_id_i <= key_id;
    do @(posedge clk_i); while (!in_ready_o);
    want = predict_heap_step(op, key_q, key_id);
    pending_tops.push_back(want);
    if (op == OP_INSERT) n_insert++;
    else n_remove++;
    if (want.status == ST_FULL) n_full++;
    if (want.status == ST_EMPTY) n_empty++;
    if (heap_fill > peak_fill) peak_fill = heap_fill;
  endtask

  // Hold the input side until every outstanding result beat has come back.
  task automatic wait_results_drained();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_tops.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Keys drawn from the whole range, or from a narrow one at either end when narrow is set, to force ties.
  function automatic logic [15:0] pick_key(bit narrow);
    if (!narrow) return 16'($urandom());
    return $urandom_range(1) ? 16'($urandom_range(3)) : 16'(16'hFFFC + $urandom_range(3));
  endfunction

  // Edge values, ties on quality and on both keys, and removes on an empty heap.
  task automatic test_directed();
    send_beat(OP_REMOVE, 16'hFFFF, 16'hFFFF);
    send_beat(OP_INSERT, 16'hFFFF, 16'hFFFF);
    send_beat(OP_INSERT, 16'hFFFF, 16'h0000);
    send_beat(OP_INSERT, 16'h0000, 16'h0000);
    send_beat(OP_INSERT, 16'h0000, 16'hFFFF);
    send_beat(OP_INSERT, 16'hFFFF, 16'h0000);
    send_beat(OP_INSERT, 16'h8000, 16'h5555);
    send_beat(OP_INSERT, 16'h7FFF, 16'hAAAA);
    send_beat(OP_INSERT, 16'h8000, 16'h5554);
    send_beat(OP_REMOVE, 16'h0000, 16'h0000);
    send_beat(OP_REMOVE, 16'h1234, 16'h4321);
    send_beat(OP_INSERT, 16'h0001, 16'h0001);
    repeat (8) send_beat(OP_REMOVE, 16'h0000, 16'h0000);
    send_beat(OP_REMOVE, 16'h0000, 16'h0000);
    wait_results_drained();
  endtask

  // Fill to capacity, push against the full heap, then drain it past empty.
  task automatic test_fill_and_drain();
    while (heap_fill < HEAP_DEPTH) begin
      send_beat(OP_INSERT, pick_key(1'($urandom_range(1))), pick_key($urandom_range(3) == 0));
    end
    repeat (3) send_beat(OP_INSERT, pick_key(1'b0), pick_key(1'b0));
    wait_results_drained();
    while (heap_fill > 0) begin
      send_beat(OP_REMOVE, pick_key(1'b0), pick_key(1'b0));
    end
    repeat (2) send_beat(OP_REMOVE, pick_key(1'b0), pick_key(1'b0));
  endtask

  // Random mix in phases of different insert weight; the third phase runs without gaps.
  task automatic test_random_mix();
    int unsigned insert_pct [4] = '{80, 50, 25, 65};
    logic        op;
    for (int ph = 0; ph < 4; ph++) begin
      gaps_on = (ph != 2);
      for (int n = 0; n < 150; n++) begin
        op = ($urandom_range(99) < insert_pct[ph]) ? OP_INSERT : OP_REMOVE;
        send_beat(op, pick_key(1'($urandom_range(1))), pick_key($urandom_range(2) == 0));
      end
    end
    gaps_on = 1'b1;
  endtask

  // Result side: random back-pressure when gaps are on.
  always @(posedge clk_i) begin
    out_ready_i <= gaps_on ? ($urandom_range(99) >= 12) : 1'b1;
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    heap_top_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tops.size() == 0) begin
        report_mismatch("unexpected result beat, count", entry_count_o, 0);
      end else begin
        want = pending_tops.pop_front();
        n_checked++;
        if (top_quality_o !== want.quality) begin
          report_mismatch("top_quality", top_quality_o, want.quality);
        end
        if (top_id_o !== want.id) report_mismatch("top_id", top_id_o, want.id);
        if (top_valid_o !== want.valid) report_mismatch("top_valid", top_valid_o, want.valid);
        if (entry_count_o !== want.count) begin
          report_mismatch("entry_count", entry_count_o, want.count);
        end
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    wait_results_drained();
    repeat (40) @(posedge clk_i);
    if (pending_tops.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_tops.size());
    end
    $display("covered %0d beats: %0d inserts, %0d removes, %0d full rejects, %0d empty rejects",
             n_insert + n_remove, n_insert, n_remove, n_full, n_empty);
    $display("checked %0d result beats, heap peaked at %0d entries", n_checked, peak_fill);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
